>>> rtl/hbfd_pkg.sv
// Shared types and constants for the half-band decimator.
package hbfd_pkg;

   typedef logic [31:0] word_type;

   // partial sum moving down the row of tap cells
   typedef struct packed {
      logic     valid;
      word_type sum;
   } chain_type;

   localparam int NUM_COEF       = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int REG_COEF_0     = 0;

   localparam int FIFO_DEPTH     = 8;
   localparam int FIFO_PTR_BITS  = 3;
   localparam int FIFO_CNT_BITS  = 4;

endpackage

>>> rtl/halfband_fir_decimator_q31_top.sv
// Half-band FIR decimate-by-two, Q1.31, built as a row of even-tap cells.
//
// At most one input item is accepted per clock cycle, while req_ready is high.
// Every other item, starting with the first after reset, yields one result: the
// even taps weighted by the coef registers (high word of each 32x32 product),
// plus the centre sample times 0.25, all summed with 32-bit wrap and doubled. A
// result passes, in order, the products and the centre term, registered at the
// accepting edge, then one adder stage per even-tap cell, then the queue write.
// The queue holds 8 results; input stalls only for an item that makes a result
// while 8 results are pending, so with the result side always ready the block
// runs at one item per cycle. The user must write coefficients through the csr
// port only while the block is idle; the block itself does not enforce it.
// Registers for taps at or beyond TAPS are ignored.
module halfband_fir_decimator_q31_top #(
   parameter int TAPS = 15
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [31:0]                    req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [31:0]                    rsp_sample_out,
   input  logic                                  csr_wr_en,
   input  logic [hbfd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [31:0]                           csr_wr_data
);

   localparam int NUM_CELLS = (TAPS + 1) / 2;
   localparam int CENTRE    = (TAPS - 1) / 2;

   logic                                accept;
   logic                                capture;
   logic                                phase_ff;
   logic [hbfd_pkg::FIFO_CNT_BITS-1:0]  credit_ff;
   logic                                rsp_accept;
   logic                                cen_valid_ff;
   hbfd_pkg::word_type                  cen_ff;
   hbfd_pkg::word_type                  win_centre;
   hbfd_pkg::word_type                  fifo_out;
   hbfd_pkg::word_type                  win_even [NUM_CELLS];
   hbfd_pkg::word_type                  win_odd  [NUM_CELLS];
   hbfd_pkg::word_type                  shift_in [NUM_CELLS];
   hbfd_pkg::chain_type                 chain    [NUM_CELLS+1];

   // phase high means the next item makes no result and needs no credit
   assign req_ready  = phase_ff || (credit_ff != hbfd_pkg::FIFO_CNT_BITS'(hbfd_pkg::FIFO_DEPTH));
   assign accept     = req_valid && req_ready;
   assign capture    = accept && !phase_ff;
   assign rsp_accept = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 1'b0;
         credit_ff <= '0;
      end else begin
         if (accept) begin
            phase_ff <= !phase_ff;
         end
         if (capture && !rsp_accept) begin
            credit_ff <= credit_ff + 1'b1;
         end else if (!capture && rsp_accept) begin
            credit_ff <= credit_ff - 1'b1;
         end
      end
   end

   for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
      localparam int LEFT = TAPS - 1 - 2 * j;
      localparam int HOLD = (LEFT >= 2) ? 2 : LEFT;

      if (j == NUM_CELLS - 1) begin : g_last
         assign shift_in[j] = req_sample_in;
      end else begin : g_mid
         assign shift_in[j] = win_even[j+1];
      end

      hbfd_cell #(
         .HOLD (HOLD),
         .LAG  (j)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .coef_wr   (csr_wr_en && (csr_index ==
                     hbfd_pkg::CSR_INDEX_BITS'(hbfd_pkg::REG_COEF_0 + j))),
         .coef_data (csr_wr_data),
         .shift     (accept),
         .shift_in  (shift_in[j]),
         .capture   (capture),
         .chain_in  (chain[j]),
         .chain_out (chain[j+1]),
         .win_even  (win_even[j]),
         .win_odd   (win_odd[j])
      );
   end

   if (CENTRE % 2 == 0) begin : g_cen_even
      assign win_centre = win_even[CENTRE/2];
   end else begin : g_cen_odd
      assign win_centre = win_odd[CENTRE/2];
   end

   // centre tap: fixed gain, arithmetic shift right by two
   always_ff @(posedge clock) begin
      if (capture) begin
         cen_ff <= {{2{win_centre[31]}}, win_centre[31:2]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cen_valid_ff <= 1'b0;
      end else begin
         cen_valid_ff <= capture;
      end
   end

   assign chain[0].valid = cen_valid_ff;
   assign chain[0].sum   = cen_ff;

   hbfd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (chain[NUM_CELLS].valid),
      .wr_data  ({chain[NUM_CELLS].sum[30:0], 1'b0}),
      .rd_valid (rsp_valid),
      .rd_ready (rsp_ready),
      .rd_data  (fifo_out)
   );

   assign rsp_sample_out = $signed(fifo_out);

endmodule

>>> rtl/hbfd_cell.sv
// One even-tap cell: sample storage, coefficient, product and one adder stage.
module hbfd_cell #(
   parameter int HOLD = 2,
   parameter int LAG  = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                coef_wr,
   input  hbfd_pkg::word_type  coef_data,
   input  logic                shift,
   input  hbfd_pkg::word_type  shift_in,
   input  logic                capture,
   input  hbfd_pkg::chain_type chain_in,
   output hbfd_pkg::chain_type chain_out,
   output hbfd_pkg::word_type  win_even,
   output hbfd_pkg::word_type  win_odd
);

   hbfd_pkg::word_type coef_ff;
   hbfd_pkg::word_type prod_ff;
   hbfd_pkg::word_type addend;
   hbfd_pkg::word_type sum_in;
   hbfd_pkg::word_type sum_ff;
   logic               valid_ff;
   logic signed [63:0] prod_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (coef_wr) begin
         coef_ff <= coef_data;
      end
   end

   // samples for taps 2j and 2j+1; the last cell sees the new item directly
   if (HOLD >= 2) begin : g_pair
      hbfd_pkg::word_type even_ff;
      hbfd_pkg::word_type odd_ff;
      always_ff @(posedge clock) begin
         if (reset) begin
            even_ff <= '0;
            odd_ff  <= '0;
         end else if (shift) begin
            even_ff <= odd_ff;
            odd_ff  <= shift_in;
         end
      end
      assign win_even = even_ff;
      assign win_odd  = odd_ff;
   end else if (HOLD == 1) begin : g_single
      hbfd_pkg::word_type even_ff;
      always_ff @(posedge clock) begin
         if (reset) begin
            even_ff <= '0;
         end else if (shift) begin
            even_ff <= shift_in;
         end
      end
      assign win_even = even_ff;
      assign win_odd  = shift_in;
   end else begin : g_none
      assign win_even = shift_in;
      assign win_odd  = shift_in;
   end

   // high word of the 64-bit product is floor(x*c / 2^32)
   assign prod_full = $signed(win_even) * $signed(coef_ff);

   always_ff @(posedge clock) begin
      if (capture) begin
         prod_ff <= prod_full[63:32];
      end
   end

   // product passes through LAG delay registers so it meets its item's partial sum
   if (LAG > 0) begin : g_lag
      hbfd_pkg::word_type lag_ff [LAG];
      always_ff @(posedge clock) begin
         lag_ff[0] <= prod_ff;
         for (int i = 1; i < LAG; i++) begin
            lag_ff[i] <= lag_ff[i-1];
         end
      end
      assign addend = lag_ff[LAG-1];
   end else begin : g_nolag
      assign addend = prod_ff;
   end

   assign sum_in = chain_in.sum + addend;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= chain_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign chain_out.valid = valid_ff;
   assign chain_out.sum   = sum_ff;

endmodule

>>> rtl/hbfd_fifo.sv
// Result queue between the tap chain and the result channel.
module hbfd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  hbfd_pkg::word_type wr_data,
   output logic               rd_valid,
   input  logic               rd_ready,
   output hbfd_pkg::word_type rd_data
);

   hbfd_pkg::word_type                   mem_ff [hbfd_pkg::FIFO_DEPTH];
   logic [hbfd_pkg::FIFO_PTR_BITS-1:0]   wr_ptr_ff;
   logic [hbfd_pkg::FIFO_PTR_BITS-1:0]   rd_ptr_ff;
   logic [hbfd_pkg::FIFO_CNT_BITS-1:0]   cnt_ff;
   logic [hbfd_pkg::FIFO_CNT_BITS-1:0]   cnt_in;
   logic                                 rd_en;

   assign rd_valid = (cnt_ff != '0);
   assign rd_en    = rd_valid && rd_ready;
   assign rd_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> tb/tb_halfband_fir_decimator_q31_top.sv
`timescale 1ns / 100ps
// Testbench for the half-band decimate-by-two filter: directed and random samples.
module tb_halfband_fir_decimator_q31_top;

   localparam int TAPS        = 15;
   localparam int CENTRE      = (TAPS - 1) / 2;
   localparam int LATENCY     = (TAPS + 1) / 2 + 2;
   localparam int STALL_LIMIT = 1000;
   localparam int IDLE_PCT    = 36;
   localparam int RANDOM_RUN  = 300;
   localparam hbfd_pkg::word_type MAX_Q31 = 32'h7FFF_FFFF;
   localparam hbfd_pkg::word_type MIN_Q31 = 32'h8000_0000;

   typedef enum int {
      COEFS_ZERO,
      COEFS_MAX,
      COEFS_MIN,
      COEFS_ALTERNATING,
      COEFS_SYMMETRIC,
      COEFS_RANDOM
   } coef_set_type;

   logic                                clock          = 1'b0;
   logic                                reset          = 1'b1;
   logic                                req_valid      = 1'b0;
   logic                                req_ready;
   logic signed [31:0]                  req_sample_in  = '0;
   logic                                rsp_valid;
   logic                                rsp_ready      = 1'b0;
   logic signed [31:0]                  rsp_sample_out;
   logic                                csr_wr_en      = 1'b0;
   logic [hbfd_pkg::CSR_INDEX_BITS-1:0] csr_index      = '0;
   logic [31:0]                         csr_wr_data    = '0;

   hbfd_pkg::word_type coef_shadow [hbfd_pkg::NUM_COEF] = '{default: '0};
   hbfd_pkg::word_type sample_history [TAPS-1] = '{default: '0};
   bit                 skip_phase = 1'b0;
   hbfd_pkg::word_type expected_out [$];
   int                 idle_pct = IDLE_PCT;
   int                 mismatches = 0;
   int                 quiet_cycles = 0;

   halfband_fir_decimator_q31_top #(.TAPS(TAPS)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   // high word of the signed 64-bit product
   function automatic hbfd_pkg::word_type high_product(input hbfd_pkg::word_type a,
                                                       input hbfd_pkg::word_type b);
      logic signed [63:0] pa;
      logic signed [63:0] pb;
      logic signed [63:0] prod;
      pa   = $signed(a);
      pb   = $signed(b);
      prod = pa * pb;
      return prod[63:32];
   endfunction

   // shift the sample into the window; every other sample yields one output
   task automatic filter_sample(input hbfd_pkg::word_type s);
      hbfd_pkg::word_type window [TAPS];
      hbfd_pkg::word_type acc;
      logic signed [31:0] centre_half;
      int                 k;
      for (k = 0; k < TAPS - 1; k++)
         window[k] = sample_history[k];
      window[TAPS-1] = s;
      if (!skip_phase) begin
         acc = '0;
         for (k = 0; k < TAPS; k += 2)
            acc += high_product(window[k], coef_shadow[k/2]);
         centre_half = $signed(window[CENTRE]) >>> 2;
         acc += centre_half;
         expected_out.push_back(acc << 1);
      end
      for (k = 0; k < TAPS - 1; k++)
         sample_history[k] = window[k+1];
      skip_phase = !skip_phase;
   endtask

   function automatic hbfd_pkg::word_type random_sample();
      case ($urandom_range(9))
         0:       return MAX_Q31;
         1:       return MIN_Q31;
         2:       return hbfd_pkg::word_type'($urandom_range(15)) - 32'd8;
         default: return $urandom();
      endcase
   endfunction

   // entered and left at a falling edge; valid stays high into the next item
   task automatic send_sample(input hbfd_pkg::word_type s);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      filter_sample(s);
      @(negedge clock);
   endtask

   // an odd item makes no output but may still be in flight, hence the extra wait
   task automatic drain_outputs();
      req_valid <= 1'b0;
      while (expected_out.size() != 0)
         @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic program_coefs(input coef_set_type pattern);
      hbfd_pkg::word_type value;
      int                 r;
      drain_outputs();
      for (r = 0; r < hbfd_pkg::NUM_COEF; r++) begin
         case (pattern)
            COEFS_ZERO:        value = '0;
            COEFS_MAX:         value = MAX_Q31;
            COEFS_MIN:         value = MIN_Q31;
            COEFS_ALTERNATING: value = r[0] ? MIN_Q31 : MAX_Q31;
            COEFS_SYMMETRIC:   value = (r < hbfd_pkg::NUM_COEF / 2)
                                       ? hbfd_pkg::word_type'($urandom())
                                       : coef_shadow[hbfd_pkg::NUM_COEF-1-r];
            default:           value = $urandom();
         endcase
         csr_wr_en   <= 1'b1;
         csr_index   <= hbfd_pkg::CSR_INDEX_BITS'(hbfd_pkg::REG_COEF_0 + r);
         csr_wr_data <= value;
         @(negedge clock);
         coef_shadow[r] = value;
      end
      csr_wr_en <= 1'b0;
   endtask

   // reset coefficients are zero, so only the fixed centre tap contributes
   task automatic test_centre_tap();
      hbfd_pkg::word_type pattern [10] = '{MAX_Q31, MIN_Q31, 32'hFFFF_FFFF, 32'd1, 32'd3,
                                           32'hFFFF_FFFC, 32'h8000_0001, 32'd0, MAX_Q31,
                                           MIN_Q31};
      int i;
      for (i = 0; i < 10; i++)
         send_sample(pattern[i]);
   endtask

   // full-scale products on every tap; the sum and the final doubling wrap
   task automatic test_full_scale_wrap();
      int i;
      program_coefs(COEFS_ALTERNATING);
      for (i = 0; i < 8; i++)
         send_sample(i < 4 ? MIN_Q31 : MAX_Q31);
   endtask

   // a lone impulse passes through odd positions, which must add nothing
   task automatic test_odd_tap_isolation();
      int i;
      program_coefs(COEFS_RANDOM);
      send_sample(MIN_Q31);
      for (i = 0; i < 6; i++)
         send_sample('0);
   endtask

   task automatic test_random_streams();
      coef_set_type sets [6] = '{COEFS_RANDOM, COEFS_MAX, COEFS_SYMMETRIC, COEFS_MIN,
                                 COEFS_ZERO, COEFS_RANDOM};
      int p;
      int i;
      for (p = 0; p < 6; p++) begin
         program_coefs(sets[p]);
         idle_pct = (p == 2) ? 0 : IDLE_PCT;
         for (i = 0; i < RANDOM_RUN; i++)
            send_sample(random_sample());
      end
      idle_pct = IDLE_PCT;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_out.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("sample_out: unexpected item %h at %0t", rsp_sample_out, $time);
         end else begin
            if (rsp_sample_out !== expected_out[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("sample_out: expected %h, got %h at %0t",
                           expected_out[0], rsp_sample_out, $time);
            end
            void'(expected_out.pop_front());
         end
      end
   end

   // watchdog: too long without any item moving on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("halfband_fir_decimator_q31_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_centre_tap();
      test_full_scale_wrap();
      test_odd_tap_isolation();
      test_random_streams();
      drain_outputs();
      if (mismatches == 0 && expected_out.size() == 0) begin
         $display("halfband_fir_decimator_q31_top: match");
      end else begin
         $display("halfband_fir_decimator_q31_top: mismatch");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/hbfd_pkg.sv
rtl/hbfd_cell.sv
rtl/hbfd_fifo.sv
rtl/halfband_fir_decimator_q31_top.sv
tb/tb_halfband_fir_decimator_q31_top.sv
